// File: sv/ntte_pkg.sv
// Shared types, constants and helper functions for the nearest-tip trail extender.
// Used by ntte_mult, ntte_seq, the top level and the testbench; depends on nothing else.
`default_nettype none

package ntte_pkg;

  localparam int PT_W      = 16;
  localparam int DIFF_W    = PT_W + 1;
  localparam int DIST_W    = 12;
  localparam int HW_W      = 10;
  localparam int TIDX_W    = 5;
  localparam int PROG_W    = 18;
  localparam int CNT16_W   = 16;
  localparam int ENT_W     = 2 * PT_W + CNT16_W;
  localparam int SQ_W      = 2 * PT_W;
  localparam int D2_W      = SQ_W + 1;
  localparam int THR_W     = 2 * DIST_W;
  localparam int MUL_W     = 27;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SRCH_W    = 58;
  localparam int K_W       = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam int MAX_TRAILS_DEF = 32;

  localparam logic [DIST_W-1:0] RST_SKIP = 12'd16;
  localparam logic [DIST_W-1:0] RST_JOIN = 12'd160;
  localparam logic [HW_W-1:0]   RST_HW   = 10'd16;

  localparam logic [CFG_IDX_W-1:0] REG_SKIP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JOIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HW   = 2'd2;

  // Progress is floor(count * 64 / 25), done as count * ceil(2^27 / 25) >> 21.
  localparam logic [MUL_W-1:0] PROG_MUL   = 27'd5368710;
  localparam int               PROG_SHIFT = 21;

  localparam logic [CNT16_W-1:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_SKIP   = 2'd0,
    ACT_EXTEND = 2'd1,
    ACT_NEW    = 2'd2,
    ACT_FULL   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MULX,
    ST_MULY,
    ST_CMP,
    ST_SQS,
    ST_SQJ,
    ST_DECIDE,
    ST_PROG,
    ST_WA,
    ST_RSQ,
    ST_SINIT,
    ST_SSTEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DIST_W-1:0] skip_distance;
    logic [DIST_W-1:0] join_distance;
    logic [HW_W-1:0]   half_width;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    action_t                  action;
    logic [TIDX_W-1:0]        trail_index;
    logic signed [PT_W-1:0]   left_x;
    logic signed [PT_W-1:0]   left_y;
    logic signed [PT_W-1:0]   right_x;
    logic signed [PT_W-1:0]   right_y;
    logic [PROG_W-1:0]        progress;
  } res_t;

  function automatic logic [PT_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] n;
    n = -v;
    return v[DIFF_W-1] ? n[PT_W-1:0] : v[PT_W-1:0];
  endfunction

  function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [PT_W+1:0] v);
    logic signed [PT_W+1:0] hi;
    logic signed [PT_W+1:0] lo;
    hi = 18'sd32767;
    lo = -18'sd32768;
    if (v > hi) begin
      return 16'sh7FFF;
    end else if (v < lo) begin
      return 16'sh8000;
    end else begin
      return v[PT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/ntte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for the trail tip table.
`default_nettype none

module ntte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/ntte_mult.sv
// Shared 27 x 27 unsigned multiplier with a registered product.
// Depends on ntte_pkg for the request type and widths.
`default_nettype none

module ntte_mult
  import ntte_pkg::*;
(
  input  wire logic              clk,
  input  wire mul_req_t          req,
  output logic      [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= PROD_W'(req.a) * PROD_W'(req.b);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// File: sv/ntte_seq.sv
// Sequencer and datapath: tip scan, threshold tests, progress and edge offset search.
// Depends on ntte_pkg and instantiates ntte_mult; talks to the tip RAM in the top level.
`default_nettype none

module ntte_seq
  import ntte_pkg::*;
#(
  parameter int MAX_TRAILS = MAX_TRAILS_DEF,
  localparam int IDX_W = (MAX_TRAILS > 1) ? $clog2(MAX_TRAILS) : 1,
  localparam int CNT_W = $clog2(MAX_TRAILS + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [PT_W-1:0] in_point_x,
  input  wire logic signed [PT_W-1:0] in_point_y,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output res_t                        res,
  output logic                        ram_we,
  output logic        [IDX_W-1:0]     ram_waddr,
  output logic        [ENT_W-1:0]     ram_wdata,
  output logic                        ram_re,
  output logic        [IDX_W-1:0]     ram_raddr,
  input  wire logic   [ENT_W-1:0]     ram_rdata
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TRAILS);
  localparam logic [K_W-1:0]   K_TOP   = K_W'(HW_W - 1);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;

  logic signed [PT_W-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic [CNT_W-1:0]         i_r, i_nxt;
  logic                     found_r, found_nxt;
  logic [D2_W-1:0]          best_r, best_nxt;
  logic [IDX_W-1:0]         bidx_r, bidx_nxt;
  logic signed [DIFF_W-1:0] bdx_r, bdx_nxt, bdy_r, bdy_nxt;
  logic [CNT16_W-1:0]       bcnt_r, bcnt_nxt;
  logic signed [DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [CNT16_W-1:0]       tcnt_r, tcnt_nxt;
  logic [SQ_W-1:0]          sqx_r, sqx_nxt;
  logic [THR_W-1:0]         skip2_r, skip2_nxt;
  action_t                  act_r, act_nxt;
  logic [IDX_W-1:0]         oidx_r, oidx_nxt;
  logic [PROG_W-1:0]        prog_r, prog_nxt;
  logic                     sel_r, sel_nxt;
  logic [K_W-1:0]           k_r, k_nxt;
  logic [HW_W-1:0]          mid_r, mid_nxt;
  logic [HW_W-1:0]          mx_r, mx_nxt, my_r, my_nxt;
  logic signed [SRCH_W-1:0] p_r, p_nxt, a_r, a_nxt, b_r, b_nxt, rr_r, rr_nxt;

  mul_req_t                 mul_req;
  logic [PROD_W-1:0]        prod;

  logic signed [PT_W-1:0]   tip_x, tip_y;
  logic [D2_W-1:0]          d2;
  logic [CNT_W-1:0]         i_inc;
  logic [THR_W-1:0]         join2;
  logic [CNT16_W-1:0]       cnt_inc;
  logic signed [SRCH_W-1:0] d2_ext, cand, a_upd;
  logic [HW_W-1:0]          mid_try;
  logic signed [DIFF_W-1:0] mx_ext, my_ext, ox, oy;
  logic signed [PT_W+1:0]   px_ext, py_ext, ox_ext, oy_ext;

  ntte_mult u_mult (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign tip_x   = ram_rdata[ENT_W-1 -: PT_W];
  assign tip_y   = ram_rdata[CNT16_W +: PT_W];
  assign d2      = D2_W'(sqx_r) + D2_W'(prod[SQ_W-1:0]);
  assign i_inc   = i_r + CNT_W'(1);
  assign join2   = prod[THR_W-1:0];
  assign cnt_inc = (bcnt_r == CNT_MAX) ? bcnt_r : bcnt_r + CNT16_W'(1);
  assign d2_ext  = SRCH_W'(best_r);
  assign cand    = p_r + a_r + b_r;
  assign a_upd   = (cand <= rr_r) ? a_r + (b_r <<< 1) : a_r;
  assign mid_try = mid_r | (HW_W'(1) << k_r);

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    i_nxt     = i_r;
    found_nxt = found_r;
    best_nxt  = best_r;
    bidx_nxt  = bidx_r;
    bdx_nxt   = bdx_r;
    bdy_nxt   = bdy_r;
    bcnt_nxt  = bcnt_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    tcnt_nxt  = tcnt_r;
    sqx_nxt   = sqx_r;
    skip2_nxt = skip2_r;
    act_nxt   = act_r;
    oidx_nxt  = oidx_r;
    prog_nxt  = prog_r;
    sel_nxt   = sel_r;
    k_nxt     = k_r;
    mid_nxt   = mid_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    p_nxt     = p_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    rr_nxt    = rr_r;

    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = bidx_r;
    ram_wdata = {px_r, py_r, cnt_inc};
    ram_re    = 1'b0;
    ram_raddr = i_r[IDX_W-1:0];
    mul_req   = '{en: 1'b0, a: '0, b: '0};

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = '0;
        if (in_valid) begin
          px_nxt    = in_point_x;
          py_nxt    = in_point_y;
          i_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = (total_r == '0) ? ST_SQS : ST_DIFF;
        end
      end
      ST_DIFF: begin
        dx_nxt    = DIFF_W'(px_r) - DIFF_W'(tip_x);
        dy_nxt    = DIFF_W'(py_r) - DIFF_W'(tip_y);
        tcnt_nxt  = ram_rdata[CNT16_W-1:0];
        state_nxt = ST_MULX;
      end
      ST_MULX: begin
        mul_req   = '{en: 1'b1, a: MUL_W'(abs_diff(dx_r)), b: MUL_W'(abs_diff(dx_r))};
        state_nxt = ST_MULY;
      end
      ST_MULY: begin
        mul_req   = '{en: 1'b1, a: MUL_W'(abs_diff(dy_r)), b: MUL_W'(abs_diff(dy_r))};
        sqx_nxt   = prod[SQ_W-1:0];
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (!found_r || d2 < best_r) begin
          found_nxt = 1'b1;
          best_nxt  = d2;
          bidx_nxt  = i_r[IDX_W-1:0];
          bdx_nxt   = dx_r;
          bdy_nxt   = dy_r;
          bcnt_nxt  = tcnt_r;
        end
        i_nxt = i_inc;
        if (i_inc < total_r) begin
          ram_re    = 1'b1;
          ram_raddr = i_inc[IDX_W-1:0];
          state_nxt = ST_DIFF;
        end else begin
          state_nxt = ST_SQS;
        end
      end
      ST_SQS: begin
        mul_req   = '{en: 1'b1, a: MUL_W'(cfg.skip_distance), b: MUL_W'(cfg.skip_distance)};
        state_nxt = ST_SQJ;
      end
      ST_SQJ: begin
        mul_req   = '{en: 1'b1, a: MUL_W'(cfg.join_distance), b: MUL_W'(cfg.join_distance)};
        skip2_nxt = prod[THR_W-1:0];
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        sel_nxt = 1'b0;
        priority if (found_r && best_r < D2_W'(skip2_r)) begin
          act_nxt   = ACT_SKIP;
          oidx_nxt  = bidx_r;
          state_nxt = ST_DONE;
        end else if (found_r && best_r < D2_W'(join2)) begin
          act_nxt   = ACT_EXTEND;
          oidx_nxt  = bidx_r;
          ram_we    = 1'b1;
          state_nxt = ST_PROG;
        end else if (total_r < MAX_CNT) begin
          act_nxt   = ACT_NEW;
          oidx_nxt  = total_r[IDX_W-1:0];
          ram_we    = 1'b1;
          ram_waddr = total_r[IDX_W-1:0];
          ram_wdata = {px_r, py_r, CNT16_W'(1)};
          total_nxt = total_r + CNT_W'(1);
          state_nxt = ST_DONE;
        end else begin
          act_nxt   = ACT_FULL;
          oidx_nxt  = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_PROG: begin
        mul_req   = '{en: 1'b1, a: MUL_W'(bcnt_r), b: PROG_MUL};
        state_nxt = ST_WA;
      end
      ST_WA: begin
        if (!sel_r) begin
          prog_nxt = prod[PROG_SHIFT +: PROG_W];
        end
        if (best_r == '0) begin
          mx_nxt    = '0;
          my_nxt    = cfg.half_width;
          state_nxt = ST_DONE;
        end else begin
          mul_req   = '{en: 1'b1, a: MUL_W'(cfg.half_width),
                        b: MUL_W'(sel_r ? abs_diff(bdx_r) : abs_diff(bdy_r))};
          state_nxt = ST_RSQ;
        end
      end
      ST_RSQ: begin
        mul_req   = '{en: 1'b1, a: prod[MUL_W-1:0], b: prod[MUL_W-1:0]};
        state_nxt = ST_SINIT;
      end
      ST_SINIT: begin
        rr_nxt    = SRCH_W'({prod, 2'b00});
        p_nxt     = d2_ext;
        a_nxt     = -(d2_ext <<< (HW_W + 1));
        b_nxt     = d2_ext <<< (2 * HW_W);
        mid_nxt   = '0;
        k_nxt     = K_TOP;
        state_nxt = ST_SSTEP;
      end
      ST_SSTEP: begin
        if (cand <= rr_r) begin
          p_nxt   = cand;
          mid_nxt = mid_try;
        end
        a_nxt = a_upd >>> 1;
        b_nxt = b_r >>> 2;
        k_nxt = k_r - K_W'(1);
        if (k_r == '0) begin
          if (!sel_r) begin
            mx_nxt    = mid_nxt;
            sel_nxt   = 1'b1;
            state_nxt = ST_WA;
          end else begin
            my_nxt    = mid_nxt;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The offset is (w*dy/m, -w*dx/m); left adds it to the point, right subtracts it.
  always_comb begin
    mx_ext = DIFF_W'(mx_r);
    my_ext = DIFF_W'(my_r);
    ox     = bdy_r[DIFF_W-1] ? -mx_ext : mx_ext;
    oy     = bdx_r[DIFF_W-1] ? my_ext : -my_ext;
    px_ext = (PT_W + 2)'(px_r);
    py_ext = (PT_W + 2)'(py_r);
    ox_ext = (PT_W + 2)'(ox);
    oy_ext = (PT_W + 2)'(oy);
    res.action      = act_r;
    res.trail_index = TIDX_W'(oidx_r);
    if (act_r == ACT_EXTEND) begin
      res.left_x   = sat_pt(px_ext + ox_ext);
      res.left_y   = sat_pt(py_ext + oy_ext);
      res.right_x  = sat_pt(px_ext - ox_ext);
      res.right_y  = sat_pt(py_ext - oy_ext);
      res.progress = prog_r;
    end else begin
      res.left_x   = '0;
      res.left_y   = '0;
      res.right_x  = '0;
      res.right_y  = '0;
      res.progress = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    i_r     <= i_nxt;
    found_r <= found_nxt;
    best_r  <= best_nxt;
    bidx_r  <= bidx_nxt;
    bdx_r   <= bdx_nxt;
    bdy_r   <= bdy_nxt;
    bcnt_r  <= bcnt_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    tcnt_r  <= tcnt_nxt;
    sqx_r   <= sqx_nxt;
    skip2_r <= skip2_nxt;
    act_r   <= act_nxt;
    oidx_r  <= oidx_nxt;
    prog_r  <= prog_nxt;
    sel_r   <= sel_nxt;
    k_r     <= k_nxt;
    mid_r   <= mid_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    p_r     <= p_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    rr_r    <= rr_nxt;
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= MAX_CNT)
    else $error("trail count exceeds table size");

  a_total_only_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_DECIDE |=> $stable(total_r))
    else $error("trail count changed outside the decision step");

  a_extend_needs_tip: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.action == ACT_EXTEND |-> found_r && total_r != '0)
    else $error("extension reported without a matched tip");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.action == ACT_EXTEND |-> mx_r <= cfg.half_width && my_r <= cfg.half_width)
    else $error("edge offset exceeds half width");

endmodule

`default_nettype wire

// File: sv/nearest_tip_trail_extender_core.sv
// Top level of the nearest-tip trail extender: configuration registers, tip RAM,
// sequencer and result register. Depends on ntte_pkg, ntte_ram and ntte_seq.
//
// Usage: a point (signed Q11.4) enters on the in_ channel as one transaction.
// The block scans every open trail tip, one tip at a time through a
// shared multiplier, then tests the nearest squared distance against the squared
// skip and join distances. The result leaves on the out_ channel with the action,
// trail index, left and right edge vertices and progress.
// A point that is skipped, starts a trail or is dropped takes no further steps;
// an extension computes its progress and, unless the point lies on the tip
// itself, runs two 10-step bit-serial searches for the edge offset.
// in_ready is high only while idle.
// A finished result sits in the output register, so the next point may be
// accepted and processed while out_ready is low; that point completes once
// the register is free.
// cfg_ writes are always accepted and must only occur while the block is idle.
// Reset (synchronous, rst_n low) restores the default distances and empties the
// trail table; no clearing pass is needed.
`default_nettype none

module nearest_tip_trail_extender_core
  import ntte_pkg::*;
#(
  parameter int MAX_TRAILS = MAX_TRAILS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic        [CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [CFG_DAT_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [PT_W-1:0]      in_point_x,
  input  wire logic signed [PT_W-1:0]      in_point_y,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic             [1:0]           out_action,
  output logic             [TIDX_W-1:0]    out_trail_index,
  output logic signed      [PT_W-1:0]      out_left_x,
  output logic signed      [PT_W-1:0]      out_left_y,
  output logic signed      [PT_W-1:0]      out_right_x,
  output logic signed      [PT_W-1:0]      out_right_y,
  output logic             [PROG_W-1:0]    out_progress
);

  localparam int IDX_W = (MAX_TRAILS > 1) ? $clog2(MAX_TRAILS) : 1;

  cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  logic             res_valid, res_ready;
  res_t             res;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  ntte_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TRAILS)
  ) u_tip_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ntte_seq #(
    .MAX_TRAILS (MAX_TRAILS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SKIP: cfg_nxt.skip_distance = cfg_data[DIST_W-1:0];
        REG_JOIN: cfg_nxt.join_distance = cfg_data[DIST_W-1:0];
        REG_HW:   cfg_nxt.half_width    = cfg_data[HW_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{skip_distance: RST_SKIP, join_distance: RST_JOIN, half_width: RST_HW};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_r.action;
  assign out_trail_index = out_r.trail_index;
  assign out_left_x      = out_r.left_x;
  assign out_left_y      = out_r.left_y;
  assign out_right_x     = out_r.right_x;
  assign out_right_y     = out_r.right_y;
  assign out_progress    = out_r.progress;

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(out_r))
    else $error("result register overwritten while stalled");

  a_no_load_during_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid_r)
    else $error("loaded result not presented");

  a_idle_when_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !res_valid |=> $stable(cfg_r) || $past(cfg_valid))
    else $error("configuration changed without a write");

endmodule

`default_nettype wire

// File: test/nearest_tip_trail_extender_core_test.sv
// Self-checking testbench for nearest_tip_trail_extender_core: a queue-fed driver, a monitor
// and a built-in trail table predictor compare every result transaction field by field.
// Depends on ntte_pkg and the nearest_tip_trail_extender_core RTL.
module nearest_tip_trail_extender_core_test
  import ntte_pkg::*;
();

  localparam int TRAIL_SLOTS = MAX_TRAILS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int WALKS       = 8;
  localparam int SETTLE      = 200;
  localparam int PRINT_CAP   = 30;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [PT_W-1:0] in_point_x = '0;
  logic signed [PT_W-1:0] in_point_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_action;
  logic [TIDX_W-1:0] out_trail_index;
  logic signed [PT_W-1:0] out_left_x;
  logic signed [PT_W-1:0] out_left_y;
  logic signed [PT_W-1:0] out_right_x;
  logic signed [PT_W-1:0] out_right_y;
  logic [PROG_W-1:0] out_progress;

  // Predicted copy of the configuration and the trail table.
  logic [DIST_W-1:0] skip_limit = RST_SKIP;
  logic [DIST_W-1:0] join_limit = RST_JOIN;
  logic [HW_W-1:0] half_width_now = RST_HW;
  logic signed [PT_W-1:0] tip_x_at[TRAIL_SLOTS];
  logic signed [PT_W-1:0] tip_y_at[TRAIL_SLOTS];
  logic [CNT16_W-1:0] tip_points[TRAIL_SLOTS];
  int unsigned trails_open = 0;

  point_t pending_points[$];
  res_t expected_results[$];
  point_t walk_heads[WALKS];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  logic hold_armed = 1'b0;
  logic receiver_hold = 1'b0;
  int mismatch_count = 0;
  int results_seen = 0;
  int settings_written = 0;
  int action_tally[4] = '{0, 0, 0, 0};
  int cycle_count = 0;

  nearest_tip_trail_extender_core #(.MAX_TRAILS(TRAIL_SLOTS)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_action(out_action),
    .out_trail_index(out_trail_index),
    .out_left_x(out_left_x),
    .out_left_y(out_left_y),
    .out_right_x(out_right_x),
    .out_right_y(out_right_y),
    .out_progress(out_progress)
  );

  always #5 clk = ~clk;

  function automatic logic signed [PT_W-1:0] saturate_q(input longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return v[PT_W-1:0];
  endfunction

  // Largest m in [0, w] with m - 1/2 <= w * a / sqrt(d2), i.e. w * a / |d| rounded half up.
  function automatic longint unsigned offset_magnitude(input longint unsigned w,
                                                       input longint unsigned a,
                                                       input longint unsigned d2);
    longint unsigned bound, lo, hi, mid, t;
    bound = 4 * w * w * a * a;
    lo = 0;
    hi = w;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * d2 <= bound) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  function automatic res_t advance_trails(input logic signed [PT_W-1:0] px,
                                          input logic signed [PT_W-1:0] py);
    res_t r;
    logic found;
    int unsigned best_i;
    longint unsigned best_d2, d2, skip_sq, join_sq;
    longint dx, dy, ox, oy, mx, my, hw, prog;
    r = '0;
    found = 1'b0;
    best_i = 0;
    best_d2 = 0;
    hw = half_width_now;
    for (int i = 0; i < trails_open; i++) begin
      dx = longint'(px) - longint'(tip_x_at[i]);
      dy = longint'(py) - longint'(tip_y_at[i]);
      d2 = dx * dx + dy * dy;
      if (!found || d2 < best_d2) begin
        found = 1'b1;
        best_d2 = d2;
        best_i = i;
      end
    end
    skip_sq = skip_limit * skip_limit;
    join_sq = join_limit * join_limit;
    if (found && best_d2 < skip_sq) begin
      r.action = ACT_SKIP;
      r.trail_index = best_i[TIDX_W-1:0];
    end else if (found && best_d2 < join_sq) begin
      dx = longint'(px) - longint'(tip_x_at[best_i]);
      dy = longint'(py) - longint'(tip_y_at[best_i]);
      if (best_d2 == 0) begin
        ox = 0;
        oy = -hw;
      end else begin
        mx = offset_magnitude(half_width_now, (dy < 0) ? -dy : dy, best_d2);
        my = offset_magnitude(half_width_now, (dx < 0) ? -dx : dx, best_d2);
        ox = (dy < 0) ? -mx : mx;
        oy = (dx < 0) ? my : -my;
      end
      r.action = ACT_EXTEND;
      r.trail_index = best_i[TIDX_W-1:0];
      r.left_x = saturate_q(longint'(px) + ox);
      r.left_y = saturate_q(longint'(py) + oy);
      r.right_x = saturate_q(longint'(px) - ox);
      r.right_y = saturate_q(longint'(py) - oy);
      prog = (longint'(tip_points[best_i]) * 256) / 100;
      r.progress = prog[PROG_W-1:0];
      tip_x_at[best_i] = px;
      tip_y_at[best_i] = py;
      if (tip_points[best_i] != CNT_MAX) begin
        tip_points[best_i] = tip_points[best_i] + 1'b1;
      end
    end else if (trails_open < TRAIL_SLOTS) begin
      r.action = ACT_NEW;
      r.trail_index = trails_open[TIDX_W-1:0];
      tip_x_at[trails_open] = px;
      tip_y_at[trails_open] = py;
      tip_points[trails_open] = CNT16_W'(1);
      trails_open++;
    end else begin
      r.action = ACT_FULL;
      r.trail_index = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < PRINT_CAP) begin
      $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : driver
    point_t next_point;
    res_t predicted;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = advance_trails(in_point_x, in_point_y);
        expected_results = {expected_results, predicted};
      end
      if (!in_valid || in_ready) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_point = pending_points.pop_front();
          in_valid <= 1'b1;
          in_point_x <= next_point.x;
          in_point_y <= next_point.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected action", out_action, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_action !== want.action) begin
          report_mismatch("action", out_action, want.action);
        end
        if (out_trail_index !== want.trail_index) begin
          report_mismatch("trail_index", out_trail_index, want.trail_index);
        end
        if (out_left_x !== want.left_x) begin
          report_mismatch("left_x", out_left_x, want.left_x);
        end
        if (out_left_y !== want.left_y) begin
          report_mismatch("left_y", out_left_y, want.left_y);
        end
        if (out_right_x !== want.right_x) begin
          report_mismatch("right_x", out_right_x, want.right_x);
        end
        if (out_right_y !== want.right_y) begin
          report_mismatch("right_y", out_right_y, want.right_y);
        end
        if (out_progress !== want.progress) begin
          report_mismatch("progress", out_progress, want.progress);
        end
        action_tally[want.action]++;
      end
      results_seen++;
    end
    out_ready <= !receiver_hold && ($urandom_range(99) >= receiver_stall_pct);
  end

  initial begin : receiver_hold_off
    wait (hold_armed);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_for_drain();
    @(negedge clk);
    while (pending_points.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SKIP: skip_limit = value[DIST_W-1:0];
      REG_JOIN: join_limit = value[DIST_W-1:0];
      REG_HW:   half_width_now = value[HW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int skip_v, input int join_v, input int hw_v);
    logic [1:0] spare;
    spare = 2'($urandom_range(3));
    write_register(REG_SKIP, skip_v[DIST_W-1:0]);
    write_register(REG_JOIN, join_v[DIST_W-1:0]);
    write_register(REG_HW, {spare, hw_v[HW_W-1:0]});
    settings_written++;
  endtask

  task automatic queue_point(input int x, input int y);
    point_t p;
    p.x = x[PT_W-1:0];
    p.y = y[PT_W-1:0];
    pending_points = {pending_points, p};
  endtask

  // Mostly short steps along a few walks so that trails get extended, with
  // exact revisits and occasional far-off points that open trails or get dropped.
  task automatic queue_walks(input int count, input int reach);
    int pick, h, sx, sy;
    point_t p;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      h = $urandom_range(WALKS - 1);
      if (pick < 10) begin
        p = walk_heads[h];
      end else if (pick < 90) begin
        sx = int'($urandom_range(2 * reach)) - reach;
        sy = int'($urandom_range(2 * reach)) - reach;
        p.x = saturate_q(longint'(walk_heads[h].x) + sx);
        p.y = saturate_q(longint'(walk_heads[h].y) + sy);
        walk_heads[h] = p;
      end else begin
        p.x = PT_W'($urandom);
        p.y = PT_W'($urandom);
        if ($urandom_range(3) == 0) begin
          p.x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end
        if (pick >= 96) begin
          walk_heads[h] = p;
        end
      end
      pending_points = {pending_points, p};
    end
  endtask

  initial begin : stimulus
    int skip_v, join_v, hw_v, reach;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_point(0, 0);
    queue_point(0, 0);
    queue_point(8, 0);
    queue_point(16, 0);
    queue_point(16, 100);
    queue_point(-32768, -32768);
    queue_point(-32768, -32668);
    queue_point(32767, 32767);
    queue_point(32667, 32767);
    queue_point(32767, -32768);
    queue_point(-32768, 32767);
    queue_point(1000, 1000);
    queue_point(1200, 1000);
    queue_point(1100, 1000);
    queue_point(1130, 1040);
    wait_for_drain();
    apply_settings(200, 100, 16);
    write_register(REG_UNUSED, CFG_DAT_W'($urandom));
    queue_point(5000, 5000);
    queue_point(5000, 5150);
    wait_for_drain();
    apply_settings(0, 160, 1023);
    queue_point(5000, 5000);
    queue_point(5000, 5060);
    queue_point(4950, 4990);

    for (int w = 0; w < WALKS; w++) begin
      walk_heads[w].x = PT_W'($urandom);
      walk_heads[w].y = PT_W'($urandom);
    end
    for (int ph = 0; ph < 8; ph++) begin
      wait_for_drain();
      case (ph)
        0: begin
          skip_v = 16; join_v = 160; hw_v = 16;
        end
        1: begin
          skip_v = 0; join_v = 4095; hw_v = 1023;
        end
        2: begin
          skip_v = 4095; join_v = 0; hw_v = 0;
        end
        3: begin
          skip_v = 200; join_v = 100; hw_v = 512;
        end
        default: begin
          skip_v = $urandom_range(300);
          join_v = skip_v + $urandom_range(2000);
          hw_v = (ph == 4) ? 0 : $urandom_range(1023);
        end
      endcase
      apply_settings(skip_v, join_v, hw_v);
      if (ph == 6) begin
        write_register(REG_UNUSED, CFG_DAT_W'($urandom));
      end
      reach = ((join_v > skip_v) ? join_v : skip_v) + join_v / 4 + 16;
      case (ph % 4)
        0: begin
          sender_idle_pct = 0; receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 54; receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0; receiver_stall_pct = 54;
        end
        default: begin
          sender_idle_pct = 28; receiver_stall_pct = 28;
        end
      endcase
      if (ph == 5) begin
        queue_walks(30, reach);
        wait_for_drain();
        queue_walks(30, reach);
      end else begin
        queue_walks(60, reach);
      end
      if (ph == 2) begin
        hold_armed = 1'b1;
      end
    end

    // Far-off points until the trail table is full, then a few dropped ones.
    wait_for_drain();
    apply_settings(16, 160, 16);
    sender_idle_pct = 28;
    receiver_stall_pct = 28;
    for (int k = 0; k < TRAIL_SLOTS + 2; k++) begin
      queue_point($urandom, $urandom);
    end
    wait_for_drain();
    repeat (SETTLE) @(posedge clk);

    $display("Checked %0d results: %0d skipped, %0d extended, %0d new trails, %0d dropped.",
             results_seen, action_tally[ACT_SKIP], action_tally[ACT_EXTEND],
             action_tally[ACT_NEW], action_tally[ACT_FULL]);
    $display("Covered %0d register settings under mixed idle, stall and hold-off patterns.",
             settings_written);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
